[rtl/core/date_check_and_ymd_difference_core_assert.svh]
// Assertion macros for the date check and difference core checker.
// Expects signals clk and rst_n in the scope of use.
`ifndef DATE_CHECK_AND_YMD_DIFFERENCE_CORE_ASSERT_SVH
`define DATE_CHECK_AND_YMD_DIFFERENCE_CORE_ASSERT_SVH

// Check cons in the same cycle that ante holds.
`define DCYMD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Check cons in the cycle after ante holds.
`define DCYMD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

[rtl/core/dcymd_pkg.sv]
// Types, constants and calendar functions for the date check and difference core.
// No dependencies; used by the core and its checker.
package dcymd_pkg;

    localparam int unsigned YEAR_W  = 12;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;

    localparam logic [YEAR_W-1:0]  MAX_YEAR_RESET = 12'd2021;
    localparam logic [MONTH_W-1:0] MONTH_JAN      = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB      = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR      = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN      = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP      = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV      = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC      = 4'd12;
    localparam logic [MONTH_W:0]   MONTHS_PER_YEAR = 5'd12;
    localparam logic [MONTH_W-1:0] MAX_DIFF_MONTHS = 4'd11;
    localparam logic [DAY_W-1:0]   MAX_DIFF_DAYS   = 5'd30;
    localparam logic [DAY_W-1:0]   DAYS_31 = 5'd31;
    localparam logic [DAY_W-1:0]   DAYS_30 = 5'd30;
    localparam logic [DAY_W-1:0]   DAYS_29 = 5'd29;
    localparam logic [DAY_W-1:0]   DAYS_28 = 5'd28;

    // Divisibility by 25 on 12 bits: multiply by the inverse mod 4096, then bound.
    localparam logic [2*YEAR_W-1:0] INV25_MOD4096 = 24'd3113;
    localparam logic [YEAR_W-1:0]   DIV25_LIMIT   = 12'd163;

    typedef enum logic [1:0] {
        ORDER_SAME          = 2'd0,
        ORDER_FIRST_EARLIER = 2'd1,
        ORDER_FIRST_LATER   = 2'd2
    } order_t;

    typedef struct packed {
        logic [5:0]         pad;
        logic [DAY_W-1:0]   second_day;
        logic [MONTH_W-1:0] second_month;
        logic [YEAR_W-1:0]  second_year;
        logic [DAY_W-1:0]   first_day;
        logic [MONTH_W-1:0] first_month;
        logic [YEAR_W-1:0]  first_year;
    } in_item_t;

    typedef struct packed {
        logic [6:0]         pad;
        logic [DAY_W-1:0]   diff_days;
        logic [MONTH_W-1:0] diff_months;
        logic [YEAR_W-1:0]  diff_years;
        order_t             order;
        logic               second_valid;
        logic               first_valid;
    } out_item_t;

    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [2*YEAR_W-1:0] prod;
        logic                div4;
        logic                div16;
        logic                div25;
        prod  = {{YEAR_W{1'b0}}, y} * INV25_MOD4096;
        div4  = (y[1:0] == 2'b00);
        div16 = (y[3:0] == 4'b0000);
        div25 = (prod[YEAR_W-1:0] <= DIV25_LIMIT);
        return (div4 && !div25) || (div16 && div25);
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        len = DAYS_31;
        if (m == MONTH_FEB)
            len = leap ? DAYS_29 : DAYS_28;
        else if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV)
            len = DAYS_30;
        return len;
    endfunction

    function automatic logic date_ok(input logic [YEAR_W-1:0]  y,
                                     input logic [MONTH_W-1:0] m,
                                     input logic [DAY_W-1:0]   d,
                                     input logic               leap,
                                     input logic [YEAR_W-1:0]  max_year);
        logic y_ok;
        logic m_ok;
        logic d_ok;
        y_ok = (y != '0) && (y <= max_year);
        m_ok = (m >= MONTH_JAN) && (m <= MONTH_DEC);
        d_ok = (d != '0) && (d <= month_len(m, leap));
        return y_ok && m_ok && d_ok;
    endfunction

endpackage

[rtl/core/date_check_and_ymd_difference_core.sv]
// Date check and year/month/day difference core, top level.
// Depends on dcymd_pkg.
//
// Usage:
//   s_tdata carries one date pair per item; m_tdata carries one result per item.
//   cfg_we/cfg_wdata write max_year, the greatest year accepted; write it only
//   while the core is empty.
//   Each item passes an input register, one stage of date checks, ordering and
//   borrow arithmetic, and a result register that drives m_tvalid and m_tdata.
//   Throughput is one item per cycle while m_tready stays high, set by the
//   single input-to-result stage. When the receiver stalls, the result register
//   holds; the input register still takes one more item, after which s_tready
//   drops until m_tready returns.
//   Reset empties both registers and sets max_year to 2021.
module date_check_and_ymd_difference_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // first_year, first_month, first_day, second_year, second_month,
    // second_day, zero pad
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // first_valid, second_valid, order, diff_years, diff_months,
    // diff_days, zero pad
    output logic [31:0] m_tdata,
    input  logic        cfg_we,
    input  logic [11:0] cfg_wdata
);

    logic                     in_valid_reg;
    dcymd_pkg::in_item_t      in_item_reg;
    logic                     out_valid_reg;
    dcymd_pkg::out_item_t     out_item_reg;
    dcymd_pkg::out_item_t     out_item_next;
    logic [11:0]              max_year_reg;
    logic                     advance;
    logic                     s_fire;

    logic        leap1;
    logic        leap2;
    logic        v1;
    logic        v2;
    logic [20:0] k1;
    logic [20:0] k2;
    logic        first_earlier;
    logic [11:0] ly;
    logic [3:0]  lm;
    logic [4:0]  ld;
    logic [11:0] ey;
    logic [3:0]  em;
    logic [4:0]  ed;
    logic        lleap;
    logic [4:0]  plen;
    logic [4:0]  ec;
    logic        day_borrow;
    logic [5:0]  dd_wide;
    logic [4:0]  lm1;
    logic        month_borrow;
    logic [4:0]  dm_wide;
    logic [11:0] dy;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            max_year_reg  <= dcymd_pkg::MAX_YEAR_RESET;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= in_valid_reg;
            if (cfg_we)
                max_year_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
            in_item_reg <= s_tdata;
        if (advance && in_valid_reg)
            out_item_reg <= out_item_next;
    end

    always_comb
    begin
        leap1 = dcymd_pkg::is_leap(in_item_reg.first_year);
        leap2 = dcymd_pkg::is_leap(in_item_reg.second_year);
        v1 = dcymd_pkg::date_ok(in_item_reg.first_year, in_item_reg.first_month,
                                in_item_reg.first_day, leap1, max_year_reg);
        v2 = dcymd_pkg::date_ok(in_item_reg.second_year, in_item_reg.second_month,
                                in_item_reg.second_day, leap2, max_year_reg);
        k1 = {in_item_reg.first_year, in_item_reg.first_month, in_item_reg.first_day};
        k2 = {in_item_reg.second_year, in_item_reg.second_month, in_item_reg.second_day};
        first_earlier = (k1 < k2);

        if (first_earlier)
        begin
            ly    = in_item_reg.second_year;
            lm    = in_item_reg.second_month;
            ld    = in_item_reg.second_day;
            lleap = leap2;
            ey    = in_item_reg.first_year;
            em    = in_item_reg.first_month;
            ed    = in_item_reg.first_day;
        end
        else
        begin
            ly    = in_item_reg.first_year;
            lm    = in_item_reg.first_month;
            ld    = in_item_reg.first_day;
            lleap = leap1;
            ey    = in_item_reg.second_year;
            em    = in_item_reg.second_month;
            ed    = in_item_reg.second_day;
        end

        // January borrows the December before it.
        plen = (lm == dcymd_pkg::MONTH_JAN) ? dcymd_pkg::DAYS_31
             : dcymd_pkg::month_len(4'(lm - 4'd1), lleap);
        ec         = (ed > plen) ? plen : ed;
        day_borrow = (ld < ed);
        dd_wide    = day_borrow ? (({1'b0, ld} + {1'b0, plen}) - {1'b0, ec})
                                : ({1'b0, ld} - {1'b0, ed});
        lm1          = day_borrow ? ({1'b0, lm} - 5'd1) : {1'b0, lm};
        month_borrow = (lm1 < {1'b0, em});
        dm_wide      = month_borrow ? ((lm1 + dcymd_pkg::MONTHS_PER_YEAR) - {1'b0, em})
                                    : (lm1 - {1'b0, em});
        dy           = month_borrow ? ((ly - 12'd1) - ey) : (ly - ey);

        out_item_next              = '0;
        out_item_next.first_valid  = v1;
        out_item_next.second_valid = v2;
        if (v1 && v2 && (k1 != k2))
        begin
            out_item_next.order       = first_earlier ? dcymd_pkg::ORDER_FIRST_EARLIER
                                                      : dcymd_pkg::ORDER_FIRST_LATER;
            out_item_next.diff_years  = dy;
            out_item_next.diff_months = dm_wide[3:0];
            out_item_next.diff_days   = dd_wide[4:0];
        end
        else
        begin
            out_item_next.order = dcymd_pkg::ORDER_SAME;
        end
    end

endmodule

[rtl/core/dcymd_checker.sv]
// Port-level checker for the date check and difference core, with its bind.
// Depends on dcymd_pkg and date_check_and_ymd_difference_core_assert.svh.
`include "date_check_and_ymd_difference_core_assert.svh"

module dcymd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    dcymd_pkg::out_item_t res;
    logic                 diffs_zero;

    assign res        = m_tdata;
    assign diffs_zero = (res.diff_years == '0) && (res.diff_months == '0)
                     && (res.diff_days == '0);

    `DCYMD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `DCYMD_ASSERT_SAME(a_invalid_zero, m_tvalid && !(res.first_valid && res.second_valid), res.order == dcymd_pkg::ORDER_SAME && diffs_zero)
    `DCYMD_ASSERT_SAME(a_same_zero, m_tvalid && res.order == dcymd_pkg::ORDER_SAME, diffs_zero)
    `DCYMD_ASSERT_SAME(a_diff_range, m_tvalid, res.diff_months <= dcymd_pkg::MAX_DIFF_MONTHS && res.diff_days <= dcymd_pkg::MAX_DIFF_DAYS)

endmodule

bind date_check_and_ymd_difference_core dcymd_checker u_dcymd_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[tb/sv/tb.sv]
// Self-checking testbench for date_check_and_ymd_difference_core.
// Holds a date-difference scoreboard class, stream drivers and the run sequence.
// Depends on dcymd_pkg and the core RTL.
module tb;
    import dcymd_pkg::*;

    localparam int HOLD_CYCLES    = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int N_SETTINGS     = 7;
    localparam int DRAIN_CYCLES   = 8;

    class date_diff_scoreboard;
        out_item_t         expected_q[$];
        logic [YEAR_W-1:0] year_max;
        int                mismatches;
        int                checked;

        function new();
            year_max   = MAX_YEAR_RESET;
            mismatches = 0;
            checked    = 0;
        endfunction

        function int unsigned days_in(input int unsigned m, input int unsigned y);
            bit leap;
            leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
            if (m == MONTH_FEB)
                return leap ? DAYS_29 : DAYS_28;
            if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV)
                return DAYS_30;
            return DAYS_31;
        endfunction

        function bit date_valid(input int unsigned y, input int unsigned m,
                                input int unsigned d);
            if (y < 1 || y > year_max)
                return 1'b0;
            if (m < MONTH_JAN || m > MONTH_DEC)
                return 1'b0;
            return d >= 1 && d <= days_in(m, y);
        endfunction

        function out_item_t predict(input in_item_t it);
            out_item_t   r;
            int unsigned ly, lm, ld, ey, em, ed, plen;
            logic [20:0] k1, k2;
            r = '0;
            r.first_valid  = date_valid(it.first_year, it.first_month, it.first_day);
            r.second_valid = date_valid(it.second_year, it.second_month, it.second_day);
            r.order        = ORDER_SAME;
            k1 = {it.first_year, it.first_month, it.first_day};
            k2 = {it.second_year, it.second_month, it.second_day};
            if (r.first_valid && r.second_valid && k1 != k2)
            begin
                if (k1 < k2)
                begin
                    r.order = ORDER_FIRST_EARLIER;
                    ly = it.second_year; lm = it.second_month; ld = it.second_day;
                    ey = it.first_year;  em = it.first_month;  ed = it.first_day;
                end
                else
                begin
                    r.order = ORDER_FIRST_LATER;
                    ly = it.first_year;  lm = it.first_month;  ld = it.first_day;
                    ey = it.second_year; em = it.second_month; ed = it.second_day;
                end
                // borrow the month before the later date, clamping the earlier day
                if (ld < ed)
                begin
                    plen = (lm == MONTH_JAN) ? DAYS_31 : days_in(lm - 1, ly);
                    if (ed > plen)
                        ed = plen;
                    ld = ld + plen - ed;
                    ed = 0;
                    lm = lm - 1;
                end
                r.diff_days = DAY_W'(ld - ed);
                if (lm < em)
                begin
                    lm = lm + 12;
                    ly = ly - 1;
                end
                r.diff_months = MONTH_W'(lm - em);
                r.diff_years  = YEAR_W'(ly - ey);
            end
            return r;
        endfunction

        function void note(input in_item_t it);
            expected_q.push_back(predict(it));
        endfunction

        function void check(input out_item_t got);
            out_item_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: result with nothing expected: %h", got);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.first_valid !== want.first_valid || got.second_valid !== want.second_valid
                || got.order !== want.order || got.diff_years !== want.diff_years
                || got.diff_months !== want.diff_months || got.diff_days !== want.diff_days)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("tb: result %0d expected v=%0d%0d ord=%0d y=%0d m=%0d d=%0d",
                             checked, want.first_valid, want.second_valid, want.order,
                             want.diff_years, want.diff_months, want.diff_days);
                    $display("tb: result %0d got      v=%0d%0d ord=%0d y=%0d m=%0d d=%0d",
                             checked, got.first_valid, got.second_valid, got.order,
                             got.diff_years, got.diff_months, got.diff_days);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_we    = 1'b0;
    logic [11:0] cfg_wdata = '0;

    date_diff_scoreboard sb = new();

    bit burst    = 1'b0;
    bit hold_req = 1'b0;
    int items_sent = 0;
    int idle_cycles = 0;

    date_check_and_ymd_difference_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    function automatic int pick_gap();
        return burst ? 0 : $urandom_range(0, 12);
    endfunction

    function automatic in_item_t mk(input int unsigned y1, input int unsigned m1,
                                    input int unsigned d1, input int unsigned y2,
                                    input int unsigned m2, input int unsigned d2);
        in_item_t r;
        r = '0;
        r.first_year   = YEAR_W'(y1);
        r.first_month  = MONTH_W'(m1);
        r.first_day    = DAY_W'(d1);
        r.second_year  = YEAR_W'(y2);
        r.second_month = MONTH_W'(m2);
        r.second_day   = DAY_W'(d2);
        return r;
    endfunction

    function automatic in_item_t random_item(input logic [11:0] ymax);
        in_item_t    r;
        int unsigned sel, near, top;
        r   = '0;
        sel = $urandom_range(0, 99);
        if (sel < 15)
        begin
            r.first_year   = YEAR_W'($urandom);
            r.first_month  = MONTH_W'($urandom);
            r.first_day    = DAY_W'($urandom);
            r.second_year  = YEAR_W'($urandom);
            r.second_month = MONTH_W'($urandom);
            r.second_day   = DAY_W'($urandom);
        end
        else
        begin
            top  = (ymax == 0) ? 4095 : ymax;
            near = $urandom_range(0, 99);
            r.first_year   = YEAR_W'($urandom_range(1, top));
            r.first_month  = MONTH_W'($urandom_range(1, 12));
            r.first_day    = DAY_W'($urandom_range(1,
                                    sb.days_in(r.first_month, r.first_year)));
            r.second_year  = (near < 35) ? r.first_year : YEAR_W'($urandom_range(1, top));
            r.second_month = (near < 20) ? r.first_month : MONTH_W'($urandom_range(1, 12));
            r.second_day   = DAY_W'($urandom_range(1,
                                    sb.days_in(r.second_month, r.second_year)));
            if (near < 6)
                r.second_day = r.first_day;
            // break one field
            if (sel < 27)
            begin
                case ($urandom_range(0, 5))
                    0: r.first_year   = YEAR_W'($urandom);
                    1: r.first_month  = MONTH_W'($urandom);
                    2: r.first_day    = DAY_W'($urandom);
                    3: r.second_year  = YEAR_W'($urandom);
                    4: r.second_month = MONTH_W'($urandom);
                    default: r.second_day = DAY_W'($urandom);
                endcase
            end
        end
        return r;
    endfunction

    task automatic send_item(input in_item_t it);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= it;
        do @(posedge clk); while (!s_tready);
        sb.note(it);
        items_sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic write_max_year(input logic [11:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.year_max = value;
    endtask

    // result side: idle, hold off on request, check each accepted item
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                gap = pick_gap();
                if (gap > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            sb.check(m_tdata);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: no progress for %0d cycles", idle_cycles);
                $display("tb: done, errors");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        logic [11:0] year_setting[N_SETTINGS];
        int          n_random[N_SETTINGS];
        in_item_t    directed_q[$];
        year_setting = '{12'd2021, 12'd4095, 12'd1, 12'd0, 12'd2400, 12'd0, 12'd2021};
        year_setting[5] = 12'($urandom_range(2, 4094));
        n_random = '{150, 150, 40, 30, 120, 100, 60};

        directed_q.push_back(mk(2020, 2, 29, 2020, 2, 29));
        directed_q.push_back(mk(2019, 3, 15, 2021, 7, 20));
        directed_q.push_back(mk(2021, 7, 20, 2019, 3, 15));
        directed_q.push_back(mk(2019, 11, 10, 2021, 3, 5));
        directed_q.push_back(mk(2020, 12, 20, 2021, 1, 5));
        directed_q.push_back(mk(2021, 1, 31, 2021, 3, 1));
        directed_q.push_back(mk(2020, 1, 31, 2020, 3, 1));
        directed_q.push_back(mk(1, 1, 1, 2021, 12, 31));
        directed_q.push_back(mk(2021, 12, 31, 1, 1, 1));
        directed_q.push_back(mk(0, 1, 1, 2000, 1, 1));
        directed_q.push_back(mk(2000, 1, 1, 2022, 1, 1));
        directed_q.push_back(mk(2000, 0, 1, 2000, 13, 1));
        directed_q.push_back(mk(2000, 15, 31, 2000, 1, 0));
        directed_q.push_back(mk(2000, 4, 31, 2000, 6, 30));
        directed_q.push_back(mk(2019, 2, 29, 2000, 2, 29));
        directed_q.push_back(mk(1900, 2, 29, 2004, 2, 29));
        directed_q.push_back(mk(4095, 15, 31, 4095, 15, 31));
        directed_q.push_back(mk(0, 0, 0, 0, 0, 0));
        directed_q.push_back(mk(2021, 5, 5, 2021, 5, 6));
        directed_q.push_back(mk(2021, 6, 15, 2020, 6, 15));

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        for (int p = 0; p < N_SETTINGS; p++)
        begin
            if (p > 0)
                write_max_year(year_setting[p]);
            if (p == 0)
            begin
                foreach (directed_q[k])
                    send_item(directed_q[k]);
            end
            if (p == 1)
            begin
                send_item(mk(1, 1, 1, 4095, 12, 31));
                send_item(mk(4095, 12, 31, 1, 1, 1));
                send_item(mk(2000, 2, 29, 4095, 2, 28));
            end
            if (p == 4)
                burst = 1'b1;
            for (int i = 0; i < n_random[p]; i++)
            begin
                if (p == 0 && i == 60)
                begin
                    hold_req = 1'b1;
                    burst    = 1'b1;
                end
                if (p == 0 && i == 90)
                    burst = 1'b0;
                if (p == 0 && i == 110)
                    drain();
                send_item(random_item(sb.year_max));
            end
            burst = 1'b0;
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("tb: %0d date pairs over %0d max_year settings, %0d results compared",
                 items_sent, N_SETTINGS, sb.checked);
        $display("tb: covered leap rules, invalid fields, borrows, a long output stall");
        $display("tb: and a pause until all results were back");
        if (sb.mismatches == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end
endmodule

[files.f]
+incdir+rtl/core
rtl/core/dcymd_pkg.sv
rtl/core/date_check_and_ymd_difference_core.sv
rtl/core/dcymd_checker.sv
tb/sv/tb.sv
